// ----- rtl/core/bbt_pkg.sv -----
// Shared constants and types for the Bollinger band tracker.
package bbt_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int PRICE_BITS   = 24;

  localparam int SLOT_W    = $clog2(WINDOW_DEPTH);
  localparam int N_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W     = PRICE_BITS + SLOT_W;
  localparam int SQ_W      = 2 * PRICE_BITS + SLOT_W;
  localparam int FRAC_BITS = 4;
  localparam int DIV_W     = SUM_W + FRAC_BITS;
  localparam int VAR_W     = 2 * SUM_W;
  localparam int RAD_W     = 2 * DIV_W;
  localparam int MUL_W     = DIV_W;
  localparam int STEP_W    = $clog2(DIV_W + 1);

  localparam int PERIOD_W     = 6;
  localparam int K_W          = 5;
  localparam int CFG_DATA_W   = 6;
  localparam int CFG_INDEX_W  = 2;
  localparam int MIDDLE_W     = 28;
  localparam int BAND_W       = 30;

  localparam int MIN_PERIOD   = 2;
  localparam int K_MAX        = 16;
  localparam int PERIOD_RESET = 20;
  localparam int BAND_RESET   = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PERIOD     = 2'd0,
    REG_BAND_WIDTH = 2'd1
  } cfg_reg_t;

endpackage

// ----- rtl/core/bbt_if.sv -----
// Valid/ready channels for price samples and band results.
interface bbt_in_if import bbt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;
  logic                  restart;

  modport source (output valid, price, restart, input ready);
  modport sink   (input valid, price, restart, output ready);
endinterface

interface bbt_out_if import bbt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     valid_res;
  logic [MIDDLE_W-1:0]      middle;
  logic [BAND_W-1:0]        upper;
  logic signed [BAND_W-1:0] lower;

  modport source (output valid, valid_res, middle, upper, lower, input ready);
  modport sink   (input valid, valid_res, middle, upper, lower, output ready);
endinterface

// ----- rtl/core/bollinger_band_tracker.sv -----
// Bollinger band tracker: moving window mean and +/- k standard deviation bands.
// Sequencing: while the window fills, a sample only updates the running sums before its word;
//   once the window is full, the word also waits on a 33-step square root and two 33-step divisions by N.
// Flow: a new sample is accepted only once the previous word has entered the output register;
//   the shared sqrt/divide/multiply datapath is busy for the whole item.
// Reset: synchronous; period 20, band width 8 quarters, window empty. No clearing pass.
module bollinger_band_tracker import bbt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  bbt_in_if.sink                 samples,
  bbt_out_if.source              bands
);

  typedef enum logic [3:0] {
    S_IDLE, S_OLD, S_SQ_OLD, S_SQ_NEW, S_NSQ, S_VAR, S_SQRT,
    S_DIV_MID, S_DIV_SD, S_OFFSET, S_BANDS, S_OUT
  } state_t;

  state_t state;

  logic [PERIOD_W-1:0]   period;
  logic [K_W-1:0]        band_width;
  logic [SLOT_W-1:0]     slot;
  logic [N_W-1:0]        fill;
  logic [SUM_W-1:0]      sum;
  logic [SQ_W-1:0]       sumsq;

  logic [PRICE_BITS-1:0] ring [WINDOW_DEPTH];
  logic [PRICE_BITS-1:0] old_q;
  logic [PRICE_BITS-1:0] price_r;
  logic                  full_r;

  logic [2*MUL_W-1:0]    mul_r;
  logic [SQ_W+N_W-1:0]   nsq_r;
  logic [VAR_W-1:0]      ssq_r;
  logic [RAD_W-1:0]      rad;
  logic [RAD_W-1:0]      root;
  logic [RAD_W-1:0]      sbit;
  logic [DIV_W-1:0]      dq;
  logic [N_W-1:0]        rem;
  logic [STEP_W-1:0]     step;
  logic [DIV_W-1:0]      mid_r;

  logic                     res_valid;
  logic [MIDDLE_W-1:0]      res_mid;
  logic [BAND_W-1:0]        res_upper;
  logic [BAND_W-1:0]        res_lower;

  logic                     out_valid;
  logic                     out_valid_res;
  logic [MIDDLE_W-1:0]      out_mid;
  logic [BAND_W-1:0]        out_upper;
  logic [BAND_W-1:0]        out_lower;

  // combinational
  logic                  accept;
  logic [N_W-1:0]        n_len;
  logic [K_W-1:0]        k_eff;
  logic [SLOT_W-1:0]     slot_eff;
  logic [N_W-1:0]        fill_eff;
  logic                  full_now;
  logic [SLOT_W-1:0]     slot_inc;
  logic [N_W:0]          old_wide;
  logic [SLOT_W-1:0]     old_addr;
  logic [MUL_W-1:0]      mul_a;
  logic [MUL_W-1:0]      mul_b;
  logic [SQ_W+N_W-1:0]   nsq_full;
  logic [SQ_W+N_W-1:0]   var_diff;
  logic [VAR_W-1:0]      var_val;
  logic [RAD_W-1:0]      sq_t;
  logic                  sq_ge;
  logic [N_W:0]          div_sh;
  logic                  div_ge;
  logic [N_W-1:0]        rem_next;
  logic [DIV_W-1:0]      dq_next;
  logic                  div_last;
  logic [BAND_W-1:0]     offset;
  logic [BAND_W-1:0]     upper_val;
  logic [BAND_W-1:0]     lower_val;

  assign accept = samples.valid && samples.ready;
  assign samples.ready = (state == S_IDLE);

  assign bands.valid     = out_valid;
  assign bands.valid_res = out_valid_res;
  assign bands.middle    = out_mid;
  assign bands.upper     = out_upper;
  assign bands.lower     = out_lower;

  always_comb begin
    if (int'(period) < MIN_PERIOD) begin
      n_len = N_W'(MIN_PERIOD);
    end else if (int'(period) > WINDOW_DEPTH) begin
      n_len = N_W'(WINDOW_DEPTH);
    end else begin
      n_len = N_W'(period);
    end
    k_eff = (int'(band_width) > K_MAX) ? K_W'(K_MAX) : band_width;
  end

  // Restart empties the window before this sample goes in.
  always_comb begin
    slot_eff = samples.restart ? '0 : slot;
    fill_eff = samples.restart ? '0 : fill;
    full_now = (fill_eff >= n_len);
    slot_inc = (int'(slot_eff) == WINDOW_DEPTH - 1) ? '0 : slot_eff + 1'b1;
    old_wide = (N_W+1)'(slot_eff) + (N_W+1)'(WINDOW_DEPTH) - (N_W+1)'(n_len);
    if (int'(old_wide) >= WINDOW_DEPTH) begin
      old_addr = SLOT_W'(old_wide - (N_W+1)'(WINDOW_DEPTH));
    end else begin
      old_addr = SLOT_W'(old_wide);
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_OLD: begin
        mul_a = MUL_W'(old_q);
        mul_b = MUL_W'(old_q);
      end
      S_SQ_OLD: begin
        mul_a = MUL_W'(price_r);
        mul_b = MUL_W'(price_r);
      end
      S_SQ_NEW: begin
        mul_a = MUL_W'(sum);
        mul_b = MUL_W'(sum);
      end
      S_OFFSET: begin
        mul_a = MUL_W'(k_eff);
        mul_b = dq;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    nsq_full = (SQ_W+N_W)'(sumsq) * (SQ_W+N_W)'(n_len);
    var_diff = nsq_r - (SQ_W+N_W)'(ssq_r);
    var_val  = (nsq_r > (SQ_W+N_W)'(ssq_r)) ? var_diff[VAR_W-1:0] : '0;

    sq_t  = root + sbit;
    sq_ge = (rad >= sq_t);

    div_sh   = {rem, dq[DIV_W-1]};
    div_ge   = (div_sh >= {1'b0, n_len});
    rem_next = div_ge ? N_W'(div_sh - {1'b0, n_len}) : N_W'(div_sh);
    dq_next  = {dq[DIV_W-2:0], div_ge};
    div_last = (step == STEP_W'(DIV_W - 1));

    offset    = mul_r[BAND_W+1:2];
    upper_val = mid_r[BAND_W-1:0] + offset;
    lower_val = mid_r[BAND_W-1:0] - offset;
  end

  // Sample ring, read-before-write
  always_ff @(posedge clk) begin
    if (accept) begin
      old_q <= ring[old_addr];
      ring[slot_eff] <= samples.price;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      period     <= PERIOD_W'(PERIOD_RESET);
      band_width <= K_W'(BAND_RESET);
      slot       <= '0;
      fill       <= '0;
      sum        <= '0;
      sumsq      <= '0;
      out_valid  <= 1'b0;
    end else begin
      mul_r <= (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

      if (bands.valid && bands.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_PERIOD: begin
            period <= cfg_data[PERIOD_W-1:0];
            slot   <= '0;
            fill   <= '0;
            sum    <= '0;
            sumsq  <= '0;
          end
          REG_BAND_WIDTH: begin
            band_width <= cfg_data[K_W-1:0];
            slot       <= '0;
            fill       <= '0;
            sum        <= '0;
            sumsq      <= '0;
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            price_r <= samples.price;
            full_r  <= full_now;
            slot    <= slot_inc;
            fill    <= full_now ? n_len : fill_eff + 1'b1;
            if (samples.restart) begin
              sum   <= '0;
              sumsq <= '0;
            end
            state <= S_OLD;
          end
        end
        S_OLD: begin
          sum   <= sum + SUM_W'(price_r) - (full_r ? SUM_W'(old_q) : '0);
          state <= S_SQ_OLD;
        end
        S_SQ_OLD: begin
          if (full_r) begin
            sumsq <= sumsq - mul_r[SQ_W-1:0];
          end
          state <= S_SQ_NEW;
        end
        S_SQ_NEW: begin
          sumsq <= sumsq + mul_r[SQ_W-1:0];
          if (fill != n_len) begin
            res_valid <= 1'b0;
            res_mid   <= '0;
            res_upper <= '0;
            res_lower <= '0;
            state     <= S_OUT;
          end else begin
            state <= S_NSQ;
          end
        end
        S_NSQ: begin
          nsq_r <= nsq_full;
          ssq_r <= mul_r[VAR_W-1:0];
          state <= S_VAR;
        end
        S_VAR: begin
          rad   <= {var_val, {(2*FRAC_BITS){1'b0}}};
          root  <= '0;
          sbit  <= RAD_W'(1) << (RAD_W - 2);
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_ge) begin
            rad  <= rad - sq_t;
            root <= (root >> 1) + sbit;
          end else begin
            root <= root >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit[0]) begin
            dq    <= {sum, {FRAC_BITS{1'b0}}};
            rem   <= '0;
            step  <= '0;
            state <= S_DIV_MID;
          end
        end
        S_DIV_MID: begin
          if (div_last) begin
            mid_r <= dq_next;
            dq    <= root[DIV_W-1:0];
            rem   <= '0;
            step  <= '0;
            state <= S_DIV_SD;
          end else begin
            dq   <= dq_next;
            rem  <= rem_next;
            step <= step + 1'b1;
          end
        end
        S_DIV_SD: begin
          dq   <= dq_next;
          rem  <= rem_next;
          step <= step + 1'b1;
          if (div_last) begin
            state <= S_OFFSET;
          end
        end
        S_OFFSET: begin
          state <= S_BANDS;
        end
        S_BANDS: begin
          res_valid <= 1'b1;
          res_mid   <= mid_r[MIDDLE_W-1:0];
          res_upper <= upper_val;
          res_lower <= lower_val;
          state     <= S_OUT;
        end
        S_OUT: begin
          // wait for the output register to free up
          if (!out_valid || bands.ready) begin
            out_valid     <= 1'b1;
            out_valid_res <= res_valid;
            out_mid       <= res_mid;
            out_upper     <= res_upper;
            out_lower     <= res_lower;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the Bollinger band tracker: directed table, random phases, band predictor.
module tb_top;
  import bbt_pkg::*;

  localparam int ITEM_TARGET = 1100;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 150;
  localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;
  localparam logic [CFG_INDEX_W-1:0] SPARE_REG_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] SPARE_REG_HI = 2'd3;

  typedef struct packed {
    logic                valid_res;
    logic [MIDDLE_W-1:0] middle;
    logic [BAND_W-1:0]   upper;
    logic [BAND_W-1:0]   lower;
  } band_word_t;

  localparam band_word_t NOT_FULL = '0;

  typedef enum logic [1:0] {ROW_WORD, ROW_WORD_CHK, ROW_CFG} row_kind_t;
  typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_EXTREME, SPREAD_FLAT} price_shape_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_INDEX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0]   data;
    logic [PRICE_BITS-1:0]   price;
    logic                    restart;
    band_word_t              want;
  } step_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bbt_in_if  price_ch ();
  bbt_out_if band_ch ();

  bollinger_band_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (price_ch),
    .bands     (band_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predictor state
  logic [PRICE_BITS-1:0] hist_prices [WINDOW_DEPTH];
  int unsigned           hist_slot;
  int unsigned           hist_count;
  longint unsigned       hist_sum;
  longint unsigned       hist_sqsum;
  logic [PERIOD_W-1:0]   cur_period = PERIOD_RESET;
  logic [K_W-1:0]        cur_quarters = BAND_RESET;

  band_word_t band_q [$];
  int         mismatch_count;
  int         words_sent;
  bit         quiet;
  int         idle_cycles;
  step_row_t  script [0:22];

  function automatic void clear_window();
    hist_slot  = 0;
    hist_count = 0;
    hist_sum   = 0;
    hist_sqsum = 0;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic band_word_t predict_bands(logic [PRICE_BITS-1:0] price, logic restart);
    int unsigned     n;
    int unsigned     old_slot;
    longint unsigned k, old, p, nsq, ssq, spread, mid, sd, offset, low_v;
    band_word_t      res;
    n = cur_period;
    if (n < MIN_PERIOD) n = MIN_PERIOD;
    if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
    if (restart) clear_window();
    if (hist_count > n) hist_count = n;
    if (hist_count == n) begin
      old_slot   = (hist_slot + WINDOW_DEPTH - n) % WINDOW_DEPTH;
      old        = hist_prices[old_slot];
      hist_sum   = hist_sum - old;
      hist_sqsum = hist_sqsum - old * old;
    end else begin
      hist_count++;
    end
    p = price;
    hist_prices[hist_slot] = price;
    hist_sum   = hist_sum + p;
    hist_sqsum = hist_sqsum + p * p;
    hist_slot  = (hist_slot + 1) % WINDOW_DEPTH;
    res = NOT_FULL;
    if (hist_count != n) return res;
    k = cur_quarters;
    if (k > K_MAX) k = K_MAX;
    nsq    = n * hist_sqsum;
    ssq    = hist_sum * hist_sum;
    spread = (nsq > ssq) ? nsq - ssq : 64'd0;
    mid    = (hist_sum * 16) / n;
    sd     = floor_sqrt(spread * 256) / n;
    offset = (k * sd) >> 2;
    low_v  = mid - offset;
    res.valid_res = 1'b1;
    res.middle    = mid[MIDDLE_W-1:0];
    res.upper     = BAND_W'(mid + offset);
    res.lower     = low_v[BAND_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [BAND_W-1:0] got, logic [BAND_W-1:0] want);
    $display("MISMATCH %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // idle the sender, let every pending word drain, then write one register
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    price_ch.valid <= 1'b0;
    while (band_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PERIOD: begin
        cur_period = val[PERIOD_W-1:0];
        clear_window();
      end
      REG_BAND_WIDTH: begin
        cur_quarters = val[K_W-1:0];
        clear_window();
      end
      default: ;
    endcase
  endtask

  task automatic push_sample(logic [PRICE_BITS-1:0] price, logic restart, bit typed,
                             band_word_t typed_want);
    int         gap;
    band_word_t pred;
    gap = quiet ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      price_ch.valid <= 1'b0;
    end
    @(negedge clk);
    price_ch.valid   <= 1'b1;
    price_ch.price   <= price;
    price_ch.restart <= restart;
    do @(posedge clk); while (price_ch.ready !== 1'b1);
    pred = predict_bands(price, restart);
    band_q.push_back(typed ? typed_want : pred);
    words_sent++;
  endtask

  // result side: random stalls, compare each word with the oldest expectation
  initial begin
    int         stall;
    band_word_t want;
    band_ch.ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 19);
      repeat (stall) begin
        @(negedge clk);
        band_ch.ready <= 1'b0;
      end
      @(negedge clk);
      band_ch.ready <= 1'b1;
      do @(posedge clk); while (band_ch.valid !== 1'b1);
      if (band_q.size() == 0) begin
        report_mismatch("unexpected word, middle", BAND_W'(band_ch.middle), '0);
      end else begin
        want = band_q.pop_front();
        if (band_ch.valid_res !== want.valid_res)
          report_mismatch("valid_res", BAND_W'(band_ch.valid_res), BAND_W'(want.valid_res));
        if (band_ch.middle !== want.middle)
          report_mismatch("middle", BAND_W'(band_ch.middle), BAND_W'(want.middle));
        if (band_ch.upper !== want.upper)
          report_mismatch("upper", band_ch.upper, want.upper);
        if (band_ch.lower !== want.lower)
          report_mismatch("lower", band_ch.lower, want.lower);
      end
    end
  end

  always @(posedge clk) begin
    if ((price_ch.valid === 1'b1 && price_ch.ready === 1'b1) ||
        (band_ch.valid === 1'b1 && band_ch.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int                    burst;
    int                    span_bits;
    price_shape_t          shape;
    logic [PRICE_BITS-1:0] base;
    logic [PRICE_BITS-1:0] next_price;
    logic [CFG_DATA_W-1:0] cfg_val;

    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_PERIOD;
    cfg_data         = '0;
    price_ch.valid   = 1'b0;
    price_ch.price   = '0;
    price_ch.restart = 1'b0;
    quiet            = 1'b0;
    idle_cycles      = 0;
    mismatch_count   = 0;
    words_sent       = 0;
    clear_window();

    // N=2 with k=16 on prices {0, max}: mid 8M, sd 8M, bands 8M +/- 32M
    script = '{
      '{ROW_WORD_CHK, REG_PERIOD, 6'd0, 24'd0, 1'b0, NOT_FULL},
      '{ROW_WORD_CHK, REG_PERIOD, 6'd0, PRICE_MAX, 1'b1, NOT_FULL},
      '{ROW_CFG, REG_PERIOD, 6'd2, 24'd0, 1'b0, NOT_FULL},
      '{ROW_CFG, REG_BAND_WIDTH, 6'd16, 24'd0, 1'b0, NOT_FULL},
      '{ROW_WORD_CHK, REG_PERIOD, 6'd0, 24'd0, 1'b0, NOT_FULL},
      '{ROW_WORD_CHK, REG_PERIOD, 6'd0, PRICE_MAX, 1'b0,
        '{1'b1, 28'd134217720, 30'd671088600, -30'sd402653160}},
      '{ROW_WORD_CHK, REG_PERIOD, 6'd0, PRICE_MAX, 1'b0,
        '{1'b1, 28'd268435440, 30'd268435440, 30'd268435440}},
      '{ROW_WORD_CHK, REG_PERIOD, 6'd0, 24'd0, 1'b1, NOT_FULL},
      '{ROW_WORD, REG_PERIOD, 6'd0, 24'd5, 1'b0, NOT_FULL},
      '{ROW_CFG, REG_BAND_WIDTH, 6'd0, 24'd0, 1'b0, NOT_FULL},
      '{ROW_WORD_CHK, REG_PERIOD, 6'd0, 24'd100, 1'b0, NOT_FULL},
      '{ROW_WORD_CHK, REG_PERIOD, 6'd0, 24'd200, 1'b0,
        '{1'b1, 28'd2400, 30'd2400, 30'd2400}},
      '{ROW_CFG, REG_PERIOD, 6'd0, 24'd0, 1'b0, NOT_FULL},
      '{ROW_CFG, REG_BAND_WIDTH, 6'd31, 24'd0, 1'b0, NOT_FULL},
      '{ROW_WORD_CHK, REG_PERIOD, 6'd0, 24'd1, 1'b0, NOT_FULL},
      '{ROW_WORD_CHK, REG_PERIOD, 6'd0, 24'd3, 1'b0,
        '{1'b1, 28'd32, 30'd96, -30'sd32}},
      '{ROW_CFG, REG_PERIOD, 6'd1, 24'd0, 1'b0, NOT_FULL},
      '{ROW_WORD_CHK, REG_PERIOD, 6'd0, 24'd7, 1'b0, NOT_FULL},
      '{ROW_WORD, REG_PERIOD, 6'd0, 24'd9, 1'b0, NOT_FULL},
      '{ROW_CFG, SPARE_REG_LO, 6'd63, 24'd0, 1'b0, NOT_FULL},
      '{ROW_WORD, REG_PERIOD, 6'd0, 24'd11, 1'b0, NOT_FULL},
      '{ROW_CFG, SPARE_REG_HI, 6'd0, 24'd0, 1'b0, NOT_FULL},
      '{ROW_WORD, REG_PERIOD, 6'd0, PRICE_MAX, 1'b0, NOT_FULL}
    };

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG)
        write_reg(script[i].idx, script[i].data);
      else
        push_sample(script[i].price, script[i].restart, script[i].kind == ROW_WORD_CHK,
                    script[i].want);
    end

    // random phases: new settings, then a burst long enough to fill the window
    while (words_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       cfg_val = 6'd0;
        1:       cfg_val = 6'd1;
        2:       cfg_val = 6'd2;
        3:       cfg_val = 6'd32;
        4:       cfg_val = 6'd33;
        5:       cfg_val = 6'd63;
        default: cfg_val = CFG_DATA_W'($urandom_range(2, 32));
      endcase
      write_reg(REG_PERIOD, cfg_val);
      case ($urandom_range(0, 7))
        0:       cfg_val = 6'd0;
        1:       cfg_val = 6'd16;
        2:       cfg_val = 6'd17;
        3:       cfg_val = 6'd63;
        default: cfg_val = CFG_DATA_W'($urandom_range(0, 63));
      endcase
      write_reg(REG_BAND_WIDTH, cfg_val);
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? SPARE_REG_HI : SPARE_REG_LO,
                  CFG_DATA_W'($urandom_range(0, 63)));

      shape     = price_shape_t'($urandom_range(0, 3));
      base      = PRICE_BITS'($urandom);
      span_bits = $urandom_range(0, 23);
      burst     = $urandom_range(40, 110);
      repeat (burst) begin
        case (shape)
          SPREAD_FULL:   next_price = PRICE_BITS'($urandom);
          SPREAD_NARROW: next_price = base + PRICE_BITS'($urandom & ((32'd1 << span_bits) - 1));
          SPREAD_EXTREME: begin
            case ($urandom_range(0, 2))
              0:       next_price = '0;
              1:       next_price = PRICE_MAX;
              default: next_price = PRICE_BITS'($urandom);
            endcase
          end
          default: next_price = ($urandom_range(0, 15) == 0) ? PRICE_BITS'($urandom) : base;
        endcase
        push_sample(next_price, $urandom_range(0, 39) == 0, 1'b0, NOT_FULL);
      end
    end

    @(negedge clk);
    price_ch.valid <= 1'b0;
    while (band_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- bollinger_band_tracker.f -----
rtl/core/bbt_pkg.sv
rtl/core/bbt_if.sv
rtl/core/bollinger_band_tracker.sv
verif/tb_top.sv
